@@ hw/rtl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// ile_pkg: shared codes for the indexed list engine
// Operation codes, result status codes and the widths of the fixed fields.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

   // width of the operation field
   localparam int OP_W     = 3;
   // width of the status field
   localparam int STATUS_W = 2;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam op_type OP_APPEND = 3'd0;
   localparam op_type OP_INSERT = 3'd1;
   localparam op_type OP_READ   = 3'd2;
   localparam op_type OP_MODIFY = 3'd3;
   localparam op_type OP_DELETE = 3'd4;

   // result status codes
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/ile_ram.sv @@
// ----------------------------------------------------------------------------
// ile_ram: simple dual-port word memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// indexed_list_engine: bounded ordered list of signed words
// Words kept in position order in one word memory; append, insert, read,
// modify and delete by position, one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation per item (op, position, value); the
//   block takes a new item only when the previous one has finished its
//   memory work. rsp channel returns one item per request: the word read
//   (all ones unless a read hit), a status, the count after the operation
//   and an empty flag.
//   From acceptance, append, modify, delete of the last word and rejected
//   operations go straight to the result state; a read passes the read
//   state first. Insert moves the tail up from the last word, then writes
//   the new word; delete at p moves the words after p down one place:
//   every moved word needs one pass through the memory's single read port
//   and single write port. The result state then loads the output register.
//   Reset empties the list at once; the word memory is not cleared, since
//   only positions below the count are ever read.
//   The result sits in an output register; a stalled receiver does not stop
//   the next item from being taken and worked, only its result waits until
//   the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   localparam int CNT_W     = $clog2(DEPTH + 1),
   localparam int REQ_W     = ile_pkg::OP_W + CNT_W + DATA_WIDTH,
   localparam int REQ_TW    = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W     = DATA_WIDTH + ile_pkg::STATUS_W + CNT_W + 1,
   localparam int RSP_TW    = ((RSP_W + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // fields from bit 0: op, position, value
   input  wire logic [REQ_TW-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // fields from bit 0: read_value, status, entry_count, is_empty
   output logic      [RSP_TW-1:0] rsp_tdata
);

   import ile_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   // control states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_UP   = 3'd2;
   localparam logic [2:0] S_INSW = 3'd3;
   localparam logic [2:0] S_DOWN = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [DATA_WIDTH-1:0] res_value_ff, res_value_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   op_type                req_op;
   logic [CNT_W-1:0]      req_pos;
   logic [DATA_WIDTH-1:0] req_value;
   logic                  accept;
   logic                  out_free;

   // request fields
   assign req_op    = req_tdata[OP_W-1:0];
   assign req_pos   = req_tdata[OP_W +: CNT_W];
   assign req_value = req_tdata[OP_W + CNT_W +: DATA_WIDTH];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // word memory
   ile_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: decode, shift passes and result hand-off
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in      = req_value;
               pos_in        = ADDR_W'(req_pos);
               res_value_in  = '1;
               res_status_in = ST_DONE;
               state_in      = S_DONE;
               unique case (req_op) inside
                  OP_APPEND, OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else if (req_op == OP_APPEND || req_pos >= count_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = ADDR_W'(count_ff);
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        // move the tail up, starting from the last word
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(count_ff - 1'b1);
                        idx_in   = ADDR_W'(count_ff - 1'b1);
                        count_in = count_ff + 1'b1;
                        state_in = S_UP;
                     end
                  end
                  OP_READ: begin
                     if (req_pos < count_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(req_pos);
                        state_in = S_READ;
                     end else begin
                        res_status_in = ST_RANGE;
                     end
                  end
                  OP_MODIFY: begin
                     if (req_pos < count_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(req_pos);
                        wr_data = req_value;
                     end else begin
                        res_status_in = ST_RANGE;
                     end
                  end
                  OP_DELETE: begin
                     if (req_pos < count_ff) begin
                        count_in = count_ff - 1'b1;
                        // move the tail down unless the last word goes
                        if (req_pos + 1'b1 < count_ff) begin
                           rd_en    = 1'b1;
                           rd_addr  = ADDR_W'(req_pos + 1'b1);
                           idx_in   = ADDR_W'(req_pos + 1'b1);
                           state_in = S_DOWN;
                        end
                     end else begin
                        res_status_in = ST_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            res_value_in = rd_data;
            state_in     = S_DONE;
         end
         S_UP: begin
            // word read last cycle moves one place up
            wr_en   = 1'b1;
            wr_addr = idx_ff + 1'b1;
            wr_data = rd_data;
            if (idx_ff == pos_ff) begin
               state_in = S_INSW;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - 1'b1;
               idx_in  = idx_ff - 1'b1;
            end
         end
         S_INSW: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = value_ff;
            state_in = S_DONE;
         end
         S_DOWN: begin
            // word read last cycle moves one place down
            wr_en   = 1'b1;
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data;
            if (CNT_W'(idx_ff) == count_ff) begin
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // result item
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TW'({(rsp_count_ff == '0), rsp_count_ff, rsp_status_ff,
                                rsp_value_ff});

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list count above depth");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write of the same word in one cycle");

   a_full_at_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == CNT_W'(DEPTH)))
      else $error("full status with room left");

   a_quiet_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid_ff)
      else $error("result item right after reset");

endmodule

`default_nettype wire
